### rtl/core/dcd_pkg.sv
// Shared constants, types and curve table builders for the detune decoder.
package dcd_pkg;

  // Detune type codes; any other code selects the default mode
  localparam logic [2:0] TypeDeci   = 3'd2;
  localparam logic [2:0] TypeCents  = 3'd3;
  localparam logic [2:0] TypeFifths = 3'd4;

  // Field widths
  localparam int TypeW   = 3;
  localparam int CoarseW = 14;
  localparam int FineW   = 14;
  localparam int OutW    = 28;
  localparam int WeightW = 13;   // fine position fraction, 1/8192 steps
  localparam int SumW    = 38;   // Q16 cents accumulator
  localparam int EntryW  = 27;   // curve sample, Q16 cents, unsigned

  // Coarse step sizes and octave size in Q16 cents
  localparam logic [EntryW-1:0] StepDeciQ16    = 27'd655360;
  localparam logic [EntryW-1:0] StepCentsQ16   = 27'd6553600;
  localparam logic [EntryW-1:0] StepFifthQ16   = 27'd46003323;
  localparam logic [EntryW-1:0] StepDefaultQ16 = 27'd3276800;
  localparam logic [EntryW-1:0] OctaveQ16      = 27'd78643200;

  // Linear fine slopes, Q16 cents per fine step
  localparam logic [EntryW-1:0] FineDeciSlope    = 27'd80;
  localparam logic [EntryW-1:0] FineDefaultSlope = 27'd280;

  // Curve table geometry, split into even and odd samples
  localparam int CurveEntries = 257;
  localparam int IdxW         = $clog2(CurveEntries);
  localparam int EvenDepth    = (CurveEntries + 1) / 2;
  localparam int OddDepth     = CurveEntries / 2;
  localparam int EvenAw       = $clog2(EvenDepth);
  localparam int OddAw        = $clog2(OddDepth);

  localparam longint unsigned Q30One        = 64'd1 << 30;
  localparam longint unsigned Ln2Q30        = 64'd744261118;
  localparam longint unsigned Log2Of1000Q30 = 64'd10700679396;
  localparam longint unsigned CurveSpan     = 64'(CurveEntries - 1);

  typedef logic [EntryW-1:0] even_rom_t [EvenDepth];
  typedef logic [EntryW-1:0] odd_rom_t  [OddDepth];

  // Two neighboring curve samples and the weight between them
  typedef struct packed {
    logic [EntryW-1:0]  e0;
    logic [EntryW-1:0]  e1;
    logic [WeightW-1:0] w;
  } curve_pt_t;

  // 2^y in Q30, y in Q30; series for the fraction part, shift for the integer part
  function automatic longint unsigned exp2_q30(longint unsigned y);
    longint unsigned ip, z, t, s;
    ip = (y >> 30) & 64'd31;
    z  = ((y & (Q30One - 64'd1)) * Ln2Q30) >> 30;
    t  = Q30One;
    s  = Q30One;
    t = ((t * z) >> 30) / 1;  s = s + t;
    t = ((t * z) >> 30) / 2;  s = s + t;
    t = ((t * z) >> 30) / 3;  s = s + t;
    t = ((t * z) >> 30) / 4;  s = s + t;
    t = ((t * z) >> 30) / 5;  s = s + t;
    t = ((t * z) >> 30) / 6;  s = s + t;
    t = ((t * z) >> 30) / 7;  s = s + t;
    t = ((t * z) >> 30) / 8;  s = s + t;
    t = ((t * z) >> 30) / 9;  s = s + t;
    t = ((t * z) >> 30) / 10; s = s + t;
    t = ((t * z) >> 30) / 11; s = s + t;
    t = ((t * z) >> 30) / 12; s = s + t;
    return s << ip;
  endfunction

  // One curve sample in Q16 cents, rounded half up
  function automatic longint unsigned curve_entry(bit tens, longint unsigned i);
    longint unsigned k, p;
    k = tens ? Log2Of1000Q30 : (64'd12 << 30);
    p = exp2_q30((k * i) / CurveSpan) - Q30One;
    if (tens) begin
      return (p + 64'd81920) / 64'd163840;
    end
    return (p * 64'd1200 + 64'd33546240) / 64'd67092480;
  endfunction

  function automatic even_rom_t build_even(bit tens);
    even_rom_t r;
    for (int j = 0; j < EvenDepth; j++) begin
      r[j] = EntryW'(curve_entry(tens, longint'(2 * j)));
    end
    return r;
  endfunction

  function automatic odd_rom_t build_odd(bit tens);
    odd_rom_t r;
    for (int j = 0; j < OddDepth; j++) begin
      r[j] = EntryW'(curve_entry(tens, longint'(2 * j + 1)));
    end
    return r;
  endfunction

endpackage

### rtl/core/detune_cents_decoder.sv
// Detune decoder top level: type plus coarse and fine words to cents, fixed point.
//
//  channel | dir | tdata fields (lsb first)                          | tuser/tlast
//  s_axis  | in  | detune_type[2:0] coarse_word[16:3] fine_word[30:17] | none
//  m_axis  | out | detune_cents_q8[27:0], zero fill [31:28]           | none
//
// One item per cycle sustained while the output accepts; after the edge that takes
// its item, a result passes through the input register, the lookup/coarse multiply
// stage, the interpolation and sum stage, and round/saturate into the output register.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled output stalls the stage behind it only when that stage is full, so
// items keep entering while empty slots remain.
module detune_cents_decoder
  import dcd_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // detune_type, coarse_word, fine_word, pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // detune_cents_q8, pad
);

  localparam int Shift = 16 - FRACTION_BITS;
  localparam logic [SumW-1:0] Half   = (SumW'(1) << Shift) >> 1;
  localparam logic [SumW-1:0] PosMax = SumW'((64'd1 << (OutW - 1)) - 64'd1);
  localparam logic [SumW-1:0] NegMax = SumW'(64'd1 << (OutW - 1));

  // Stage valid bits and stage advance enables
  logic v0_q, v1_q, v2_q, v3_q;
  logic rdy0, rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready_o = rdy0;
  assign m_axis_tvalid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // ---------------- stage 0: input register
  logic [TypeW-1:0]   type_q;
  logic [CoarseW-1:0] coarse_q;
  logic [FineW-1:0]   fine_q;

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid_i) begin
      type_q   <= s_axis_tdata_i[2:0];
      coarse_q <= s_axis_tdata_i[16:3];
      fine_q   <= s_axis_tdata_i[30:17];
    end
  end

  // ---------------- stage 1: decode, curve lookup, coarse and octave parts
  logic signed [3:0]      octave_s;
  logic signed [10:0]     cstep_s;
  logic [FineW-1:0]       t_mag;
  logic                   neg;
  logic                   is_curve;
  logic [EntryW-1:0]      step;
  logic [EntryW-1:0]      slope;
  logic [EntryW-1:0]      lin_fine;
  curve_pt_t              pt;
  logic signed [SumW-1:0] coarse_prod;
  logic signed [SumW-1:0] octave_prod;
  logic [EntryW-1:0]      e0_d;
  logic [EntryW-1:0]      diff_d;

  assign octave_s = $signed(coarse_q[13:10]);
  // Coarse step above 512 wraps negative
  assign cstep_s  = (coarse_q[9:0] > 10'd512) ? $signed({1'b1, coarse_q[9:0]})
                                               : $signed({1'b0, coarse_q[9:0]});
  assign neg      = !fine_q[FineW-1];
  assign t_mag    = fine_q[FineW-1] ? {1'b0, fine_q[FineW-2:0]}
                                    : FineW'(14'd8192 - fine_q);

  // Type decode
  always_comb begin
    is_curve = 1'b0;
    case (type_q)
      TypeDeci: begin
        step  = StepDeciQ16;
        slope = FineDeciSlope;
      end
      TypeCents: begin
        step     = StepCentsQ16;
        slope    = FineDefaultSlope;
        is_curve = 1'b1;
      end
      TypeFifths: begin
        step     = StepFifthQ16;
        slope    = FineDefaultSlope;
        is_curve = 1'b1;
      end
      default: begin
        step  = StepDefaultQ16;
        slope = FineDefaultSlope;
      end
    endcase
  end

  dcd_curve_lookup u_lookup (
    .tens_i (type_q == TypeCents),
    .t_i    (t_mag),
    .pt_o   (pt)
  );

  assign lin_fine    = EntryW'(t_mag) * slope;
  assign coarse_prod = SumW'(cstep_s) * $signed(SumW'(step));
  assign octave_prod = SumW'(octave_s) * $signed(SumW'(OctaveQ16));

  // Linear modes ride the same path with a zero slope to the next sample
  assign e0_d   = is_curve ? pt.e0 : lin_fine;
  assign diff_d = is_curve ? (pt.e1 - pt.e0) : '0;

  logic signed [SumW-1:0] base_q;
  logic [EntryW-1:0]      e0_q;
  logic [EntryW-1:0]      diff_q;
  logic [WeightW-1:0]     w_q;
  logic                   neg_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      base_q <= coarse_prod + octave_prod;
      e0_q   <= e0_d;
      diff_q <= diff_d;
      w_q    <= pt.w;
      neg_q  <= neg;
    end
  end

  // ---------------- stage 2: interpolate fine part and sum in Q16
  logic [EntryW+WeightW-1:0] interp;
  logic [EntryW-1:0]         fine_mag;
  logic signed [SumW-1:0]    fine_s;
  logic signed [SumW-1:0]    sum_q;

  assign interp   = (EntryW + WeightW)'(diff_q) * (EntryW + WeightW)'(w_q);
  assign fine_mag = e0_q + interp[WeightW +: EntryW];
  assign fine_s   = neg_q ? -$signed(SumW'(fine_mag)) : $signed(SumW'(fine_mag));

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      sum_q <= base_q + fine_s;
    end
  end

  // ---------------- stage 3: round magnitude, saturate, output register
  logic [SumW-1:0] mag;
  logic [SumW-1:0] rounded;
  logic            sum_neg;
  logic [OutW-1:0] res;
  logic [OutW-1:0] res_q;

  assign sum_neg = sum_q[SumW-1];
  assign mag     = sum_neg ? SumW'(-sum_q) : SumW'(sum_q);
  assign rounded = (mag + Half) >> Shift;

  always_comb begin
    if (!sum_neg && rounded > PosMax) begin
      res = {1'b0, {(OutW-1){1'b1}}};
    end else if (sum_neg && rounded > NegMax) begin
      res = {1'b1, {(OutW-1){1'b0}}};
    end else if (sum_neg) begin
      res = -rounded[OutW-1:0];
    end else begin
      res = rounded[OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata_o = {{(32-OutW){1'b0}}, res_q};

  // ---------------- assertions
  // Curve tables rise monotonically, so the interpolation step is never negative
  a_curve_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && is_curve) |-> (pt.e1 >= pt.e0))
    else $error("curve samples out of order");

  // With every stage full and the output stalled, no item may enter
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && v1_q && v2_q && v3_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while pipeline full");

  // A delivered result with nothing behind it leaves the output empty
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !v2_q) |=> !m_axis_tvalid_o)
    else $error("result appeared without an item");

  // An item in the middle stage reaches the output stage at the next edge
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && (!v3_q || m_axis_tready_i)) |=> m_axis_tvalid_o)
    else $error("item lost between stages");

endmodule

### rtl/core/dcd_curve_lookup.sv
// Exponential fine curve lookup: sample pair and weight for a fine magnitude.
module dcd_curve_lookup
  import dcd_pkg::*;
(
  input  logic             tens_i,   // 1: 10^x curve, 0: 2^x curve
  input  logic [FineW-1:0] t_i,      // fine magnitude, 0..8192
  output curve_pt_t        pt_o
);

  localparam int PosW = FineW + IdxW;

  localparam even_rom_t TensEven  = build_even(1'b1);
  localparam odd_rom_t  TensOdd   = build_odd(1'b1);
  localparam even_rom_t FifthEven = build_even(1'b0);
  localparam odd_rom_t  FifthOdd  = build_odd(1'b0);

  logic [PosW-1:0]   pos;
  logic [IdxW-1:0]   idx;
  logic [IdxW-2:0]   half;
  logic [IdxW-1:0]   even_n;
  logic [IdxW-1:0]   odd_n;
  logic [EvenAw-1:0] even_a;
  logic [OddAw-1:0]  odd_a;
  logic [EntryW-1:0] even_v;
  logic [EntryW-1:0] odd_v;
  logic              last;

  // Table position: integer part picks the sample, low bits weight it
  assign pos  = PosW'(t_i) * PosW'(CurveEntries - 1);
  assign idx  = pos[WeightW +: IdxW];
  assign half = idx[IdxW-1:1];
  assign last = (idx == IdxW'(CurveEntries - 1));

  // Neighbors always land one in each half-table
  assign even_n = idx[0] ? IdxW'(half) + IdxW'(1) : IdxW'(half);
  assign odd_n  = IdxW'(half);
  assign even_a = (even_n >= IdxW'(EvenDepth)) ? EvenAw'(EvenDepth - 1) : even_n[EvenAw-1:0];
  assign odd_a  = (odd_n >= IdxW'(OddDepth)) ? OddAw'(OddDepth - 1) : odd_n[OddAw-1:0];

  assign even_v = tens_i ? TensEven[even_a] : FifthEven[even_a];
  assign odd_v  = tens_i ? TensOdd[odd_a] : FifthOdd[odd_a];

  // Sample order follows index parity; last sample repeats itself
  always_comb begin
    pt_o.e0 = idx[0] ? odd_v : even_v;
    pt_o.e1 = last ? pt_o.e0 : (idx[0] ? even_v : odd_v);
    pt_o.w  = pos[WeightW-1:0];
  end

endmodule

### verif/tb_detune_cents_decoder.sv
// Testbench for detune_cents_decoder: directed rows and random items checked against a cents predictor.
`timescale 1ns / 100ps

module tb_detune_cents_decoder;
  import dcd_pkg::*;

  localparam int FracBits    = 8;
  localparam int ClkHalf     = 4;
  localparam int ResetCycles = 11;
  localparam int IdleLimit   = 4000;   // cycles with no item moving on either side
  localparam int HoldCycles  = 300;    // long receiver hold-off, fills the pipe
  localparam int RandomItems = 1880;
  localparam int QuietTail   = 300;    // last random items run without idling
  localparam int HoldAtItem  = 500;
  localparam int MaxReports  = 10;
  localparam int TailCycles  = 8;      // covers the pipeline depth, leave margin
  localparam int LastEntry   = CurveEntries - 1;

  localparam int  CentsPerOctave = 1200;
  localparam int  FineCentre     = 8192;
  localparam int  FineFracBits   = 13;
  localparam int  CoarseHalf     = 512;
  localparam int  CoarseSpan     = 1024;
  localparam int  OctaveHalf     = 8;
  localparam int  OctaveSpan     = 16;
  localparam longint OutMax      = (64'sd1 <<< (OutW - 1)) - 1;
  localparam longint OutMin      = -(64'sd1 <<< (OutW - 1));

  localparam longint unsigned OneQ30      = 64'd1 << 30;
  localparam longint unsigned LnTwoQ30    = 64'd744261118;
  localparam longint unsigned Log2KiloQ30 = 64'd10700679396;
  localparam longint unsigned TwelveQ30   = 64'd12 << 30;

  // Q16 step sizes and linear fine slopes
  localparam longint DeciStepQ16  = 64'sd10 <<< 16;
  localparam longint CentStepQ16  = 64'sd100 <<< 16;
  localparam longint FifthStepQ16 = 64'sd46003323;
  localparam longint HalfStepQ16  = 64'sd50 <<< 16;
  localparam longint DeciSlope    = 80;
  localparam longint LinearSlope  = 280;

  // Spare type code, decodes to the default mode
  localparam logic [TypeW-1:0] TypeFallback = 3'd0;

  // One input item; detune_type lands in the low bits of tdata
  typedef struct packed {
    logic [FineW-1:0]   fine_word;
    logic [CoarseW-1:0] coarse_word;
    logic [TypeW-1:0]   detune_type;
  } detune_req_t;

  typedef struct {
    detune_req_t           req;
    bit                    known;
    logic signed [OutW-1:0] cents;
  } dir_row_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;

  longint curve_cents  [CurveEntries];
  longint curve_fifths [CurveEntries];

  logic signed [OutW-1:0] cents_due[$];
  detune_req_t            req_due[$];
  dir_row_t               dir_rows[$];

  int err_count = 0;
  bit idle_on   = 1'b1;
  bit hold_req  = 1'b0;

  always #(ClkHalf) clk_i = ~clk_i;

  detune_cents_decoder #(
    .FRACTION_BITS(FracBits)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // 2^y with y in Q30: series on the fraction, shift by the integer part
  function automatic longint unsigned pow2_q30(longint unsigned y);
    longint unsigned whole, z, term, acc;
    whole = (y >> 30) & 64'd31;
    z     = ((y & (OneQ30 - 64'd1)) * LnTwoQ30) >> 30;
    term  = OneQ30;
    acc   = OneQ30;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      acc  = acc + term;
    end
    return acc << whole;
  endfunction

  // Curve sample idx in Q16 cents, rounded half up
  function automatic longint curve_point(bit tens, int idx);
    longint unsigned scale, p;
    scale = tens ? Log2KiloQ30 : TwelveQ30;
    p = pow2_q30((scale * 64'(idx)) / 64'(LastEntry)) - OneQ30;
    if (tens) begin
      return longint'((p + 64'd81920) / 64'd163840);
    end
    return longint'((p * 64'd1200 + 64'd4095 * 64'd8192) / (64'd4095 * 64'd16384));
  endfunction

  // Fine detune magnitude on an exponential curve, linear between samples
  function automatic longint curve_fine_q16(bit tens, longint t);
    longint pos, k, w, e0, e1;
    pos = t * LastEntry;
    k   = pos >>> FineFracBits;
    w   = pos & ((64'sd1 <<< FineFracBits) - 1);
    e0  = tens ? curve_cents[int'(k)] : curve_fifths[int'(k)];
    if (k + 1 > LastEntry) begin
      e1 = e0;
    end else begin
      e1 = tens ? curve_cents[int'(k) + 1] : curve_fifths[int'(k) + 1];
    end
    return e0 + ((e1 - e0) * w) / (64'sd1 <<< FineFracBits);
  endfunction

  // Total detune in cents, fixed point with FracBits fraction bits
  function automatic logic signed [OutW-1:0] predict_cents_q8(detune_req_t r);
    longint octave, cstep, step_q16, fine_q16, fw, t, sum, mag, res, half;
    octave = longint'(r.coarse_word[13:10]);
    if (octave >= OctaveHalf) octave = octave - OctaveSpan;
    cstep = longint'(r.coarse_word[9:0]);
    if (cstep > CoarseHalf) cstep = cstep - CoarseSpan;
    fw = longint'(r.fine_word);
    t  = (fw >= FineCentre) ? fw - FineCentre : FineCentre - fw;
    case (r.detune_type)
      TypeDeci: begin
        step_q16 = DeciStepQ16;
        fine_q16 = t * DeciSlope;
      end
      TypeCents: begin
        step_q16 = CentStepQ16;
        fine_q16 = curve_fine_q16(1'b1, t);
      end
      TypeFifths: begin
        step_q16 = FifthStepQ16;
        fine_q16 = curve_fine_q16(1'b0, t);
      end
      default: begin
        step_q16 = HalfStepQ16;
        fine_q16 = t * LinearSlope;
      end
    endcase
    if (fw < FineCentre) fine_q16 = -fine_q16;
    sum = octave * CentsPerOctave * 65536 + cstep * step_q16 + fine_q16;
    // round the magnitude, ties away from zero, then saturate
    half = (64'sd1 <<< (16 - FracBits)) >>> 1;
    mag  = (sum < 0) ? -sum : sum;
    mag  = (mag + half) >>> (16 - FracBits);
    res  = (sum < 0) ? -mag : mag;
    if (res > OutMax) res = OutMax;
    if (res < OutMin) res = OutMin;
    return OutW'(res);
  endfunction

  task automatic add_row(logic [TypeW-1:0] ty, logic [CoarseW-1:0] cw,
                         logic [FineW-1:0] fw, bit known, logic signed [OutW-1:0] cents);
    dir_row_t row;
    row.req.detune_type = ty;
    row.req.coarse_word = cw;
    row.req.fine_word   = fw;
    row.known           = known;
    row.cents           = cents;
    dir_rows.push_back(row);
  endtask

  // Offer one item, optionally after an idle burst; log its result once taken
  task automatic offer(detune_req_t r, logic signed [OutW-1:0] cents);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, r};
    do @(posedge clk_i); while (!s_tready);
    cents_due.push_back(cents);
    req_due.push_back(r);
  endtask

  // Stimulus: directed rows, then random items, then drain and report
  initial begin
    detune_req_t r;
    int          pick;
    for (int i = 0; i < CurveEntries; i++) begin
      curve_cents[i]  = curve_point(1'b1, i);
      curve_fifths[i] = curve_point(1'b0, i);
    end

    add_row(TypeDeci,   14'd0,     14'd8192,  1, 0);
    add_row(TypeCents,  14'd0,     14'd8192,  1, 0);
    add_row(TypeFifths, 14'd0,     14'd8192,  1, 0);
    // every spare code falls back to the default mode: one octave up
    for (int k = 0; k < 8; k++) begin
      if (3'(k) != TypeDeci && 3'(k) != TypeCents && 3'(k) != TypeFifths)
        add_row(3'(k), 14'd1024, 14'd8192, 1, 307200);
    end
    add_row(TypeCents,    14'd7680,  14'd8192,  1, 15257600);   // top octave, top step
    add_row(TypeDeci,     14'd8192,  14'd8192,  1, -2457600);   // octave -8
    add_row(TypeDeci,     14'd513,   14'd8192,  1, -1308160);   // coarse wraps to -511
    add_row(TypeFifths,   14'd1,     14'd8192,  1, 179700);
    add_row(TypeFifths,   14'd0,     14'd0,     1, -307200);    // last curve point, negative
    add_row(TypeDeci,     14'd0,     14'd16383, 1, 2560);
    add_row(TypeDeci,     14'd0,     14'd0,     1, -2560);
    add_row(TypeFallback, 14'd0,     14'd0,     1, -8960);
    add_row(TypeFallback, 14'd0,     14'd16383, 1, 8959);
    add_row(TypeCents,    14'd0,     14'd0,     0, 0);
    add_row(TypeCents,    14'd0,     14'd16383, 0, 0);
    add_row(TypeCents,    14'd0,     14'd8224,  0, 0);          // exactly on a sample
    add_row(TypeCents,    14'd0,     14'd4095,  0, 0);
    add_row(TypeFifths,   14'd0,     14'd8193,  0, 0);
    add_row(TypeFifths,   14'd7680,  14'd16383, 0, 0);          // largest total
    add_row(TypeFifths,   14'd8705,  14'd0,     0, 0);          // smallest total
    add_row(TypeCents,    14'd16383, 14'd1,     0, 0);
    add_row(TypeFifths,   14'd16383, 14'd16383, 0, 0);

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].req,
            dir_rows[i].known ? dir_rows[i].cents : predict_cents_q8(dir_rows[i].req));
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == HoldAtItem) hold_req = 1'b1;
      if (n == RandomItems - QuietTail) idle_on = 1'b0;
      r.detune_type = 3'($urandom_range(0, 7));
      // coarse: mostly uniform, sometimes at wrap points
      pick = $urandom_range(0, 7);
      case (pick)
        0:       r.coarse_word = {4'($urandom_range(0, 15)), 10'd512};
        1:       r.coarse_word = {4'($urandom_range(0, 15)), 10'd513};
        2:       r.coarse_word = {$urandom_range(0, 1) ? 4'd7 : 4'd8, 10'($urandom)};
        default: r.coarse_word = 14'($urandom);
      endcase
      // fine: mostly uniform, often near the centre, sometimes at the ends
      pick = $urandom_range(0, 7);
      case (pick)
        0, 1:    r.fine_word = 14'(FineCentre - 40 + $urandom_range(0, 80));
        2:       r.fine_word = $urandom_range(0, 1) ? 14'd0 : 14'd16383;
        default: r.fine_word = 14'($urandom);
      endcase
      offer(r, predict_cents_q8(r));
    end
    s_tvalid <= 1'b0;

    while (cents_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_detune_cents_decoder: done, clean");
    end else begin
      $display("tb_detune_cents_decoder: done, errors");
    end
    $finish;
  end

  // Result side: compare each taken item, then pick the next ready level
  initial begin
    int                     stall;
    int                     hold;
    bit                     hold_done;
    logic signed [OutW-1:0] want;
    detune_req_t            src;
    stall     = 0;
    hold      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_tvalid && m_tready) begin
        if (cents_due.size() == 0) begin
          err_count++;
          if (err_count <= MaxReports)
            $display("%0t: unexpected result %0d", $time, $signed(m_tdata[OutW-1:0]));
        end else begin
          want = cents_due.pop_front();
          src  = req_due.pop_front();
          if (m_tdata[OutW-1:0] !== want) begin
            err_count++;
            if (err_count <= MaxReports)
              $display("%0t: type %0d coarse %0d fine %0d: expected %0d got %0d", $time,
                       src.detune_type, src.coarse_word, src.fine_word, want,
                       $signed(m_tdata[OutW-1:0]));
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold      = HoldCycles;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 4) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no item moves for too long
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IdleLimit) begin
        $display("tb_detune_cents_decoder: done, errors");
        $finish;
      end
    end
  end

endmodule
